/* rtl/core/gap_sensor_adaptive_detector_defines.svh */
// ----------------------------------------------------------------------------
// Gap sensor adaptive detector: assertion macros
// Shared property wrappers, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef GAP_SENSOR_ADAPTIVE_DETECTOR_DEFINES_SVH
`define GAP_SENSOR_ADAPTIVE_DETECTOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GSAD_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GSAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gsad_pkg.sv */
// ----------------------------------------------------------------------------
// gsad_pkg
// Types, widths and codes shared by the gap sensor detector modules.
// ----------------------------------------------------------------------------
package gsad_pkg;

    localparam int LIST_DEPTH  = 8;
    localparam int SAMPLE_BITS = 12;

    // configuration field widths
    localparam int LIMIT_BITS     = 12;
    localparam int BAND_BITS      = 10;
    localparam int COUNT_BITS     = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = LIMIT_BITS;

    // room for sample + margin + rise allowance without wrap
    localparam int WIDE_BITS = SAMPLE_BITS + 4;

    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int STATUS_BITS  = 2;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WIDE_BITS-1:0]   wide_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    localparam sample_t SAMPLE_MAX = '1;
    localparam count_t  COUNT_MAX  = '1;
    localparam wide_t   RISE_EXTRA = WIDE_BITS'(80);

    localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET = LIMIT_BITS'(400);
    localparam logic [BAND_BITS-1:0]  HYST_RESET      = BAND_BITS'(100);
    localparam count_t                MIN_WEB_RESET   = COUNT_BITS'(8);
    localparam count_t                MAX_WEB_RESET   = COUNT_BITS'(500);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LOW_LIMIT = 2'd0,
        CFG_HYST      = 2'd1,
        CFG_MIN_WEB   = 2'd2,
        CFG_MAX_WEB   = 2'd3
    } cfg_index_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_NORMAL   = 2'd0,
        ST_GAP      = 2'd1,
        ST_TOO_WIDE = 2'd2
    } status_t;

    // detector -> list store
    typedef struct packed {
        logic step;   // commit this request
        logic feed;   // start from cleared lists
        logic wipe;   // leave the lists cleared after this request
    } list_ctrl_t;

    // list store -> detector, values after this request's insert
    typedef struct packed {
        sample_t top_first;
        sample_t bottom_first;
        sample_t bottom_last;
    } list_view_t;

endpackage

/* rtl/core/gsad_extreme_lists.sv */
// ----------------------------------------------------------------------------
// gsad_extreme_lists
// Largest and smallest samples seen, kept sorted; parallel compare-and-shift
// insert of one sample per request.
// ----------------------------------------------------------------------------
module gsad_extreme_lists (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gsad_pkg::list_ctrl_t ctrl,
    input  gsad_pkg::sample_t    sample,
    output gsad_pkg::list_view_t view
);
    import gsad_pkg::*;

    sample_t top_reg [LIST_DEPTH];
    sample_t bot_reg [LIST_DEPTH];

    sample_t top_base [LIST_DEPTH];
    sample_t bot_base [LIST_DEPTH];
    sample_t top_ins  [LIST_DEPTH];
    sample_t bot_ins  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] above;
    logic [LIST_DEPTH-1:0] below;

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            top_base[i] = ctrl.feed ? '0 : top_reg[i];
            bot_base[i] = ctrl.feed ? SAMPLE_MAX : bot_reg[i];
            // strict compares: an equal sample lands after the existing entry
            above[i] = sample > top_base[i];
            below[i] = sample < bot_base[i];
        end
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (!above[i]) begin
                top_ins[i] = top_base[i];
            end else if (i == 0) begin
                top_ins[i] = sample;
            end else if (!above[i-1]) begin
                top_ins[i] = sample;
            end else begin
                top_ins[i] = top_base[i-1];
            end
            if (!below[i]) begin
                bot_ins[i] = bot_base[i];
            end else if (i == 0) begin
                bot_ins[i] = sample;
            end else if (!below[i-1]) begin
                bot_ins[i] = sample;
            end else begin
                bot_ins[i] = bot_base[i-1];
            end
        end
    end

    assign view.top_first    = top_ins[0];
    assign view.bottom_first = bot_ins[0];
    assign view.bottom_last  = bot_ins[LIST_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                top_reg[i] <= '0;
                bot_reg[i] <= SAMPLE_MAX;
            end
        end else if (ctrl.step) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                top_reg[i] <= ctrl.wipe ? '0 : top_ins[i];
                bot_reg[i] <= ctrl.wipe ? SAMPLE_MAX : bot_ins[i];
            end
        end
    end

endmodule

/* rtl/core/gap_sensor_adaptive_detector.sv */
// ----------------------------------------------------------------------------
// gap_sensor_adaptive_detector
// Label/gap detector on one gap sensor sample per motor step, with
// self-calibrating threshold and hysteresis.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser
//  s_      | in        | sample                        | feed_start
//  m_      | out       | threshold_now, swing          | status
//  cfg_    | in        | cfg_index / cfg_data write    | -
//
//  One request per cycle sustained while m_tready stays high; a request passes
//  the input register, then the result register, which raises result tvalid.
//  The list insert and the detector decision sit combinationally between them.
//  Reset clears lists, threshold, swing and web tracking; configuration
//  returns to its defaults.
//  A stalled m_ side holds one result while the input register still takes
//  one more request.
// ----------------------------------------------------------------------------
`include "gap_sensor_adaptive_detector_defines.svh"

module gap_sensor_adaptive_detector (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [gsad_pkg::S_TDATA_BITS-1:0]     s_tdata,   // [11:0] sample
    input  logic                                  s_tuser,   // [0] feed_start
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gsad_pkg::M_TDATA_BITS-1:0]     m_tdata,   // [11:0] threshold_now, [23:12] swing
    output logic [gsad_pkg::STATUS_BITS-1:0]      m_tuser,   // [1:0] status
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gsad_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gsad_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import gsad_pkg::*;

    // configuration
    logic [LIMIT_BITS-1:0] low_limit_reg;
    logic [BAND_BITS-1:0]  hyst_reg;
    count_t                min_web_reg;
    count_t                max_web_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg <= LOW_LIMIT_RESET;
            hyst_reg      <= HYST_RESET;
            min_web_reg   <= MIN_WEB_RESET;
            max_web_reg   <= MAX_WEB_RESET;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_LOW_LIMIT: low_limit_reg <= cfg_data[LIMIT_BITS-1:0];
                CFG_HYST:      hyst_reg      <= cfg_data[BAND_BITS-1:0];
                CFG_MIN_WEB:   min_web_reg   <= cfg_data[COUNT_BITS-1:0];
                CFG_MAX_WEB:   max_web_reg   <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic    in_valid_reg, in_valid_next;
    sample_t in_sample_reg;
    logic    in_feed_reg;
    logic    s_take;
    logic    fire;

    logic    m_valid_reg, m_valid_next;
    status_t status_reg;
    sample_t thr_out_reg;
    sample_t swing_out_reg;

    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_feed_reg   <= s_tuser;
        end
    end

    // extreme lists
    list_ctrl_t list_ctrl;
    list_view_t list_view;
    logic       wipe;

    assign list_ctrl.step = fire;
    assign list_ctrl.feed = in_feed_reg;
    assign list_ctrl.wipe = wipe;

    gsad_extreme_lists u_lists (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (list_ctrl),
        .sample  (in_sample_reg),
        .view    (list_view)
    );

    // detector state
    sample_t threshold_reg, threshold_next;
    sample_t swing_reg, swing_next;
    logic    in_web_reg, in_web_next;
    count_t  web_count_reg, web_count_next;
    status_t status_next;

    wide_t   s_w, thr_w, hyst_w, margin_w, bot_first_w, band_low_w;
    count_t  count_inc;
    logic    calibrated, rise, fall, past_min, too_long;
    sample_t renew_lo, renew_d;

    always_comb begin
        s_w         = WIDE_BITS'(in_sample_reg);
        thr_w       = WIDE_BITS'(threshold_reg);
        hyst_w      = WIDE_BITS'(hyst_reg);
        margin_w    = WIDE_BITS'(low_limit_reg >> 2);
        bot_first_w = WIDE_BITS'(list_view.bottom_first);
        band_low_w  = (thr_w > hyst_w) ? (thr_w - hyst_w) : '0;
        calibrated  = threshold_reg != '0;
        count_inc   = (web_count_reg == COUNT_MAX) ? web_count_reg : web_count_reg + 1'b1;
        past_min    = count_inc > min_web_reg;
        too_long    = count_inc > max_web_reg;

        if (calibrated) begin
            rise = s_w > (thr_w + hyst_w);
            fall = s_w < band_low_w;
        end else begin
            rise = (in_sample_reg == list_view.top_first)
                && (s_w > (bot_first_w + margin_w + RISE_EXTRA));
            fall = s_w < (bot_first_w + margin_w);
        end

        // calibrated gaps take the highest entry of the low list
        renew_lo = calibrated ? list_view.bottom_last : list_view.bottom_first;
        renew_d  = (list_view.top_first > renew_lo) ? (list_view.top_first - renew_lo) : '0;
    end

    always_comb begin
        threshold_next = threshold_reg;
        swing_next     = swing_reg;
        in_web_next    = in_web_reg;
        web_count_next = web_count_reg;
        status_next    = ST_NORMAL;
        wipe           = 1'b0;
        if (!in_web_reg) begin
            if (rise) begin
                in_web_next    = 1'b1;
                web_count_next = '0;
            end
        end else begin
            web_count_next = count_inc;
            if (past_min) begin
                if (fall) begin
                    in_web_next    = 1'b0;
                    web_count_next = '0;
                    status_next    = ST_GAP;
                    swing_next     = renew_d;
                    threshold_next = renew_lo + (renew_d >> 1);
                end else if (too_long) begin
                    in_web_next    = 1'b0;
                    web_count_next = '0;
                    status_next    = ST_TOO_WIDE;
                    threshold_next = '0;
                    wipe           = calibrated ? in_feed_reg : 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            swing_reg     <= '0;
            in_web_reg    <= 1'b0;
            web_count_reg <= '0;
        end else if (fire) begin
            threshold_reg <= threshold_next;
            swing_reg     <= swing_next;
            in_web_reg    <= in_web_next;
            web_count_reg <= web_count_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg    <= status_next;
            thr_out_reg   <= threshold_next;
            swing_out_reg <= swing_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_TDATA_BITS'({swing_out_reg, thr_out_reg});

    // checks
    `GSAD_ASSERT_HOLDS(a_wide_drops_thr, m_valid_reg && (status_reg == ST_TOO_WIDE),
        thr_out_reg == '0, "too-wide result with a live threshold")
    `GSAD_ASSERT_NEXT(a_gap_leaves_web, fire && (status_next == ST_GAP),
        !in_web_reg && (web_count_reg == '0), "gap did not close the web")
    `GSAD_ASSERT_HOLDS(a_count_idle, !in_web_reg,
        web_count_reg == '0, "web counter running outside a web")

endmodule
